// ===== src/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants of the spectral bin log quantizer.
// ----------------------------------------------------------------------------
package sbq_pkg;

  // Bins at or above this index are never processed
  localparam int unsigned MaxBins = 2048;
  // Upper clamp of the rounding bias, 0.999 in Q.16
  localparam logic [15:0] BiasMax = 16'd65470;
  // Quotient bits of the log quantizer divide
  localparam int unsigned QBits = 23;

  // Register indexes of the configuration port
  localparam logic [2:0] RegQuantStep  = 3'd0;
  localparam logic [2:0] RegQuantBias  = 3'd1;
  localparam logic [2:0] RegThreshold  = 3'd2;
  localparam logic [2:0] RegShape      = 3'd3;
  localparam logic [2:0] RegDry        = 3'd4;
  localparam logic [2:0] RegAmpLimit   = 3'd5;
  localparam logic [2:0] RegBandBegin  = 3'd6;
  localparam logic [2:0] RegBandEnd    = 3'd7;

  typedef struct packed {
    logic [10:0]        bin_index;
    logic signed [23:0] real_in;
    logic signed [23:0] imag_in;
  } sbq_in_t;

  typedef struct packed {
    logic signed [23:0] real_out;
    logic signed [23:0] imag_out;
    logic               in_band;
    logic               saturated;
  } sbq_out_t;

  // Data that rides along the pipeline with each bin
  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               in_band;
    logic               zero;
    logic [21:0]        l2;
  } sbq_side_t;

endpackage

// ===== src/sbq_mag.sv =====
// ----------------------------------------------------------------------------
// sbq_mag
// Band check, squared magnitude plus threshold, and log2 in Q.16 (4 stages).
// ----------------------------------------------------------------------------
module sbq_mag (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sbq_pkg::sbq_in_t    data_i,
  input  logic [47:0]         thr_i,
  input  logic [11:0]         band_begin_i,
  input  logic [11:0]         band_end_i,
  output logic                valid_o,
  output sbq_pkg::sbq_side_t  side_o
);
  import sbq_pkg::*;

  logic [3:0] vld_q;

  // stage 1: squares and band check
  logic signed [23:0] re1_q, im1_q;
  logic               inb1_q;
  logic [46:0]        sqr1_q, sqi1_q;
  logic signed [47:0] sqr_full, sqi_full;
  logic               inb_d;

  assign sqr_full = data_i.real_in * data_i.real_in;
  assign sqi_full = data_i.imag_in * data_i.imag_in;
  assign inb_d = ({1'b0, data_i.bin_index} >= band_begin_i) &&
                 ({1'b0, data_i.bin_index} < band_end_i) &&
                 ({5'd0, data_i.bin_index} < 16'(MaxBins));

  // stage 2: sum
  logic signed [23:0] re2_q, im2_q;
  logic               inb2_q;
  logic [48:0]        n2_q;

  // stage 3: leading one search
  logic signed [23:0] re3_q, im3_q;
  logic               inb3_q, zero3_q;
  logic [48:0]        n3_q;
  logic [5:0]         p3_q;
  logic [5:0]         p_d;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < 49; i++) begin
      if (n2_q[i]) p_d = 6'(i);
    end
  end

  // stage 4: normalize and take mantissa
  logic [48:0] norm;
  assign norm = n3_q << (6'd48 - p3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re1_q  <= data_i.real_in;
      im1_q  <= data_i.imag_in;
      inb1_q <= inb_d;
      sqr1_q <= sqr_full[46:0];
      sqi1_q <= sqi_full[46:0];

      re2_q  <= re1_q;
      im2_q  <= im1_q;
      inb2_q <= inb1_q;
      n2_q   <= {2'b0, sqr1_q} + {2'b0, sqi1_q} + {1'b0, thr_i};

      re3_q   <= re2_q;
      im3_q   <= im2_q;
      inb3_q  <= inb2_q;
      zero3_q <= (n2_q == '0);
      n3_q    <= n2_q;
      p3_q    <= p_d;

      side_o.re      <= re3_q;
      side_o.im      <= im3_q;
      side_o.in_band <= inb3_q;
      side_o.zero    <= zero3_q;
      side_o.l2      <= {p3_q, norm[47:32]};
    end
  end

  assign valid_o = vld_q[3];

endmodule

// ===== src/sbq_div.sv =====
// ----------------------------------------------------------------------------
// sbq_div
// Log quantizer divide: q = floor((l2*2^16 + bias*step) / (step*2^16)),
// one numerator setup stage then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module sbq_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sbq_pkg::sbq_side_t  side_i,
  input  logic [22:0]         step_i,
  input  logic [15:0]         bias_i,
  output logic                valid_o,
  output sbq_pkg::sbq_side_t  side_o,
  output logic [22:0]         quo_o
);
  import sbq_pkg::*;

  logic              vld_q  [QBits+1];
  logic [39:0]       rem_q  [QBits+1];
  logic [QBits-1:0]  quo_q  [QBits+1];
  sbq_side_t         side_q [QBits+1];
  logic [38:0]       bs;

  assign bs = bias_i * step_i;

  // numerator setup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {2'b0, side_i.l2, 16'd0} + {1'b0, bs};
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  // quotient bit stages, MSB first
  for (genvar s = 0; s < QBits; s++) begin : g_stage
    localparam int Sh = QBits - 1 - s;
    logic [63:0] dsh;
    logic        ge;

    assign dsh = {25'd0, step_i, 16'd0} << Sh;
    assign ge  = {24'd0, rem_q[s]} >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? rem_q[s] - dsh[39:0] : rem_q[s];
        quo_q[s+1]  <= {quo_q[s][QBits-2:0], ge};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[QBits];
  assign side_o  = side_q[QBits];
  assign quo_o   = quo_q[QBits];

endmodule

// ===== src/sbq_gain.sv =====
// ----------------------------------------------------------------------------
// sbq_gain
// Log difference, shaping, exp2 ratio with clip, bin scaling and saturation.
// ----------------------------------------------------------------------------
module sbq_gain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sbq_pkg::sbq_side_t  side_i,
  input  logic [22:0]         quo_i,
  input  logic [22:0]         step_i,
  input  logic [17:0]         shape_i,
  input  logic [16:0]         dry_i,
  input  logic [22:0]         amp_i,
  output logic                valid_o,
  output sbq_pkg::sbq_out_t   data_o
);
  import sbq_pkg::*;

  logic [4:0] vld_q;

  // G1: q * step
  sbq_side_t   s1_q;
  logic [45:0] prod_full;
  logic [23:0] prod1_q;
  assign prod_full = quo_i * step_i;

  // G2: diff and shaping product
  sbq_side_t          s2_q;
  logic signed [24:0] diff;
  logic signed [43:0] mul2_q;
  assign diff = $signed({1'b0, prod1_q}) - $signed({3'b0, s1_q.l2});

  // G3: exp2, clip, coefficient
  sbq_side_t          s3_q;
  logic signed [24:0] coef3_q;
  logic signed [26:0] half;
  logic signed [10:0] k;
  logic [16:0]        base;
  logic [10:0]        negk;
  logic [23:0]        ratio, ratio_c;
  assign half = 27'(mul2_q >>> 17);
  assign k    = half[26:16];
  assign base = {1'b1, half[15:0]};
  assign negk = 11'(-k);

  always_comb begin
    if (k >= 11'sd8) begin
      ratio = {1'b0, amp_i};
    end else if (k >= 11'sd0) begin
      ratio = {7'd0, base} << k[2:0];
    end else if (k <= -11'sd17) begin
      ratio = '0;
    end else begin
      ratio = {7'd0, base >> negk[4:0]};
    end
    ratio_c = (ratio > {1'b0, amp_i}) ? {1'b0, amp_i} : ratio;
  end

  // G4: scale both parts
  sbq_side_t          s4_q;
  logic signed [48:0] pr4_q, pi4_q;

  // G5: floor shift and saturate into the output register
  logic signed [32:0] shr, shi;
  logic               cr_hi, cr_lo, ci_hi, ci_lo;
  logic signed [23:0] sr, si;
  assign shr   = 33'(pr4_q >>> 16);
  assign shi   = 33'(pi4_q >>> 16);
  assign cr_hi = shr > 33'sd8388607;
  assign cr_lo = shr < -33'sd8388608;
  assign ci_hi = shi > 33'sd8388607;
  assign ci_lo = shi < -33'sd8388608;
  assign sr = cr_hi ? 24'sh7FFFFF : (cr_lo ? 24'sh800000 : shr[23:0]);
  assign si = ci_hi ? 24'sh7FFFFF : (ci_lo ? 24'sh800000 : shi[23:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= side_i;
      prod1_q <= prod_full[23:0];

      s2_q   <= s1_q;
      mul2_q <= diff * $signed({1'b0, shape_i});

      s3_q    <= s2_q;
      coef3_q <= $signed({1'b0, ratio_c}) - $signed({8'd0, dry_i});

      s4_q  <= s3_q;
      pr4_q <= s3_q.re * coef3_q;
      pi4_q <= s3_q.im * coef3_q;

      if (!s4_q.in_band) begin
        data_o <= '{real_out: s4_q.re, imag_out: s4_q.im, in_band: 1'b0, saturated: 1'b0};
      end else if (s4_q.zero) begin
        data_o <= '{real_out: '0, imag_out: '0, in_band: 1'b1, saturated: 1'b0};
      end else begin
        data_o <= '{real_out: sr, imag_out: si, in_band: 1'b1,
                    saturated: cr_hi | cr_lo | ci_hi | ci_lo};
      end
    end
  end

  assign valid_o = vld_q[4];

endmodule

// ===== src/spectral_bin_log_quantizer.sv =====
// ----------------------------------------------------------------------------
// spectral_bin_log_quantizer
// Per-bin log2 quantization of complex spectrum bins with amplitude reshaping.
// ----------------------------------------------------------------------------
// Pipeline: 4 magnitude/log stages, 24 quantizer divide stages (the bit-per-stage
//   divide and its numerator setup) and 5 gain and output stages.
// Throughput: one bin per cycle; a stalled output freezes the whole pipeline.
// Reset: clears all stage valid bits and loads register reset values.
module spectral_bin_log_quantizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbq_pkg::sbq_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbq_pkg::sbq_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);
  import sbq_pkg::*;

  logic [22:0] step_q;
  logic [15:0] bias_q;
  logic [47:0] thr_q;
  logic [17:0] shape_q;
  logic [16:0] dry_q;
  logic [22:0] amp_q;
  logic [11:0] band_begin_q, band_end_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= 23'd262144;
      bias_q       <= 16'd32768;
      thr_q        <= '0;
      shape_q      <= 18'd65536;
      dry_q        <= '0;
      amp_q        <= 23'd262144;
      band_begin_q <= '0;
      band_end_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegQuantStep: step_q       <= cfg_data_i[22:0];
        RegQuantBias: bias_q       <= cfg_data_i[15:0];
        RegThreshold: thr_q        <= cfg_data_i;
        RegShape:     shape_q      <= cfg_data_i[17:0];
        RegDry:       dry_q        <= cfg_data_i[16:0];
        RegAmpLimit:  amp_q        <= cfg_data_i[22:0];
        RegBandBegin: band_begin_q <= cfg_data_i[11:0];
        RegBandEnd:   band_end_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // effective step and bias
  logic [22:0] step_eff;
  logic [15:0] bias_eff;
  assign step_eff = (step_q == '0) ? 23'd1 : step_q;
  assign bias_eff = (bias_q > BiasMax) ? BiasMax : bias_q;

  // global pipeline advance
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic      mag_valid, div_valid;
  sbq_side_t mag_side, div_side;
  logic [22:0] quo;

  sbq_mag u_mag (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .data_i(in_data_i),
    .thr_i(thr_q), .band_begin_i(band_begin_q), .band_end_i(band_end_q),
    .valid_o(mag_valid), .side_o(mag_side)
  );

  sbq_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(mag_valid), .side_i(mag_side),
    .step_i(step_eff), .bias_i(bias_eff),
    .valid_o(div_valid), .side_o(div_side), .quo_o(quo)
  );

  sbq_gain u_gain (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(div_valid), .side_i(div_side), .quo_i(quo),
    .step_i(step_eff), .shape_i(shape_q), .dry_i(dry_q), .amp_i(amp_q),
    .valid_o(out_valid_o), .data_o(out_data_o)
  );

  // checks
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("held result lost");

  a_pass_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.in_band) |-> !out_data_o.saturated)
    else $error("pass-through bin flagged saturated");

endmodule
